>>> rtl/core/tsfm_pkg.sv
package tsfm_pkg;

   localparam int ADC_BITS    = 12;
   localparam int SUM_W       = ADC_BITS + 2;
   localparam int GROUP_LEN   = 3;
   localparam int BURST_LEN   = 9;
   localparam int CNT_W       = 4;
   localparam int THR_W       = 12;
   localparam int CFG_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int FRAC_BITS   = 16;
   localparam int DISP_W      = 16;
   localparam int CMP_W       = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
   localparam int RECIP_SHIFT = SUM_W + 1;
   localparam int RECIP3      = ((1 << RECIP_SHIFT) + GROUP_LEN - 1) / GROUP_LEN;
   localparam int DIV_W       = SUM_W + RECIP_SHIFT;
   localparam int PROD_W      = CFG_W + ADC_BITS + 1;
   localparam int ACC_W       = PROD_W + 2;
   localparam int QUOT_W      = ACC_W - FRAC_BITS;

   localparam logic signed [CFG_W-1:0] RST_GAIN_XX = -32'sd5427;
   localparam logic signed [CFG_W-1:0] RST_GAIN_XY = 32'sd52;
   localparam logic signed [CFG_W-1:0] RST_OFF_X   = 32'sd21324460;
   localparam logic signed [CFG_W-1:0] RST_GAIN_YX = 32'sd537;
   localparam logic signed [CFG_W-1:0] RST_GAIN_YY = 32'sd8424;
   localparam logic signed [CFG_W-1:0] RST_OFF_Y   = -32'sd2188524;
   localparam logic [THR_W-1:0]        RST_THRESH  = 12'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_X_FROM_X     = 3'd0,
      CSR_GAIN_X_FROM_Y     = 3'd1,
      CSR_OFFSET_X          = 3'd2,
      CSR_GAIN_Y_FROM_X     = 3'd3,
      CSR_GAIN_Y_FROM_Y     = 3'd4,
      CSR_OFFSET_Y          = 3'd5,
      CSR_OUTLIER_THRESHOLD = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NOISY  = 2'd1,
      STATUS_PEN_UP = 2'd2
   } status_type;

   typedef logic [ADC_BITS-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] gain_xx;
      logic signed [CFG_W-1:0] gain_xy;
      logic signed [CFG_W-1:0] off_x;
      logic signed [CFG_W-1:0] gain_yx;
      logic signed [CFG_W-1:0] gain_yy;
      logic signed [CFG_W-1:0] off_y;
      logic [THR_W-1:0]        threshold;
   } cfg_type;

   typedef struct packed {
      logic             pen_up;
      sum_type [2:0]    x_sum;
      sum_type [2:0]    y_sum;
   } burst_type;

   typedef struct packed {
      logic             pen_up;
      sample_type [2:0] x_avg;
      sample_type [2:0] y_avg;
   } avg_type;

   typedef struct packed {
      status_type status;
      sample_type raw_x;
      sample_type raw_y;
   } point_type;

   typedef struct packed {
      logic       ok;
      sample_type value;
   } axis_type;

   // truncating divide by three through the reciprocal
   function automatic sample_type div3(sum_type s);
      logic [DIV_W-1:0] p;
      p = DIV_W'(s) * DIV_W'(RECIP3);
      return ADC_BITS'(p >> RECIP_SHIFT);
   endfunction

   function automatic sample_type absdiff(sample_type a, sample_type b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic axis_type filter_axis(sample_type [2:0] a, logic [THR_W-1:0] thr);
      sample_type      d0;
      sample_type      d1;
      sample_type      d2;
      logic [ADC_BITS:0] pair;
      axis_type        r;
      d0 = absdiff(a[0], a[1]);
      d1 = absdiff(a[1], a[2]);
      d2 = absdiff(a[2], a[0]);
      r.ok = !((CMP_W'(d0) > CMP_W'(thr)) && (CMP_W'(d1) > CMP_W'(thr))
               && (CMP_W'(d2) > CMP_W'(thr)));
      if (d0 < d1) begin
         if (d2 < d0) pair = {1'b0, a[0]} + {1'b0, a[2]};
         else         pair = {1'b0, a[0]} + {1'b0, a[1]};
      end else if (d2 < d1) begin
         pair = {1'b0, a[0]} + {1'b0, a[2]};
      end else begin
         pair = {1'b0, a[1]} + {1'b0, a[2]};
      end
      r.value = pair[ADC_BITS:1];
      return r;
   endfunction

   // Q31.16 sum truncated toward zero, saturated to the display width
   function automatic logic signed [DISP_W-1:0] to_display(logic signed [ACC_W-1:0] acc);
      logic signed [QUOT_W-1:0] q;
      logic                     over;
      q = QUOT_W'(acc >>> FRAC_BITS);
      if (acc[ACC_W-1] && (|acc[FRAC_BITS-1:0])) q = q + QUOT_W'(1);
      over = !((&q[QUOT_W-1:DISP_W-1]) || !(|q[QUOT_W-1:DISP_W-1]));
      if (over && !q[QUOT_W-1]) return {1'b0, {(DISP_W-1){1'b1}}};
      if (over)                 return {1'b1, {(DISP_W-1){1'b0}}};
      return q[DISP_W-1:0];
   endfunction

endpackage

>>> rtl/core/tsfm_if.sv
interface tsfm_req_if;
   import tsfm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_x;
   sample_type sample_y;
   logic       pen_down;
   modport source(output valid, output sample_x, output sample_y, output pen_down,
                  input ready);
   modport sink(input valid, input sample_x, input sample_y, input pen_down,
                output ready);
endinterface

interface tsfm_rsp_if;
   import tsfm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               burst_status;
   sample_type               filtered_raw_x;
   sample_type               filtered_raw_y;
   logic signed [DISP_W-1:0] display_x;
   logic signed [DISP_W-1:0] display_y;
   modport source(output valid, output burst_status, output filtered_raw_x,
                  output filtered_raw_y, output display_x, output display_y,
                  input ready);
   modport sink(input valid, input burst_status, input filtered_raw_x,
                input filtered_raw_y, input display_x, input display_y,
                output ready);
endinterface

>>> rtl/core/tsfm_csr.sv
module tsfm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tsfm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsfm_pkg::CFG_W-1:0]        csr_wdata,
   output tsfm_pkg::cfg_type                 cfg
);
   import tsfm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_X_FROM_X:     cfg_in.gain_xx   = csr_wdata;
            CSR_GAIN_X_FROM_Y:     cfg_in.gain_xy   = csr_wdata;
            CSR_OFFSET_X:          cfg_in.off_x     = csr_wdata;
            CSR_GAIN_Y_FROM_X:     cfg_in.gain_yx   = csr_wdata;
            CSR_GAIN_Y_FROM_Y:     cfg_in.gain_yy   = csr_wdata;
            CSR_OFFSET_Y:          cfg_in.off_y     = csr_wdata;
            CSR_OUTLIER_THRESHOLD: cfg_in.threshold = csr_wdata[THR_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_xx   <= RST_GAIN_XX;
         cfg_ff.gain_xy   <= RST_GAIN_XY;
         cfg_ff.off_x     <= RST_OFF_X;
         cfg_ff.gain_yx   <= RST_GAIN_YX;
         cfg_ff.gain_yy   <= RST_GAIN_YY;
         cfg_ff.off_y     <= RST_OFF_Y;
         cfg_ff.threshold <= RST_THRESH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/tsfm_accum.sv
module tsfm_accum (
   input  logic                  clock,
   input  logic                  reset,
   tsfm_req_if.sink              req,
   output logic                  burst_valid,
   input  logic                  burst_ready,
   output tsfm_pkg::burst_type   burst
);
   import tsfm_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   sum_type [2:0]    x_sum_ff;
   sum_type [2:0]    x_sum_in;
   sum_type [2:0]    y_sum_ff;
   sum_type [2:0]    y_sum_in;
   sum_type [2:0]    x_add;
   sum_type [2:0]    y_add;
   logic             burst_valid_ff;
   logic             burst_valid_in;
   burst_type        burst_ff;
   logic [1:0]       grp;
   logic             accept;
   logic             last;
   logic             done;
   logic             load;

   assign load      = !burst_valid_ff || burst_ready;
   assign req.ready = load;
   assign accept    = req.valid && load;

   always_comb begin
      if (count_ff < CNT_W'(GROUP_LEN))          grp = 2'd0;
      else if (count_ff < CNT_W'(2 * GROUP_LEN)) grp = 2'd1;
      else                                       grp = 2'd2;
      x_add      = x_sum_ff;
      y_add      = y_sum_ff;
      x_add[grp] = x_sum_ff[grp] + SUM_W'(req.sample_x);
      y_add[grp] = y_sum_ff[grp] + SUM_W'(req.sample_y);
      last       = (count_ff == CNT_W'(BURST_LEN - 1));
      done       = last || !req.pen_down;
      x_sum_in   = x_sum_ff;
      y_sum_in   = y_sum_ff;
      count_in   = count_ff;
      if (accept) begin
         if (done) begin
            x_sum_in = '0;
            y_sum_in = '0;
            count_in = '0;
         end else begin
            x_sum_in = x_add;
            y_sum_in = y_add;
            count_in = count_ff + CNT_W'(1);
         end
      end
      burst_valid_in = load ? (accept && done) : burst_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         x_sum_ff       <= '0;
         y_sum_ff       <= '0;
         burst_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         x_sum_ff       <= x_sum_in;
         y_sum_ff       <= y_sum_in;
         burst_valid_ff <= burst_valid_in;
      end
      if (accept && done) begin
         burst_ff.pen_up <= !last;
         burst_ff.x_sum  <= x_add;
         burst_ff.y_sum  <= y_add;
      end
   end

   assign burst_valid = burst_valid_ff;
   assign burst       = burst_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BURST_LEN - 1))
      else $error("burst count out of range");

   a_lift_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !req.pen_down) |=> (count_ff == '0) && (x_sum_ff == '0))
      else $error("pen lift did not clear burst");

endmodule

>>> rtl/core/tsfm_filter.sv
module tsfm_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  tsfm_pkg::cfg_type     cfg,
   input  logic                  burst_valid,
   output logic                  burst_ready,
   input  tsfm_pkg::burst_type   burst,
   output logic                  point_valid,
   input  logic                  point_ready,
   output tsfm_pkg::point_type   point
);
   import tsfm_pkg::*;

   logic      avg_valid_ff;
   avg_type   avg_ff;
   avg_type   avg_in;
   logic      avg_load;
   logic      point_valid_ff;
   point_type point_ff;
   point_type point_in;
   logic      point_load;
   axis_type  ax;
   axis_type  ay;

   assign point_load  = !point_valid_ff || point_ready;
   assign avg_load    = !avg_valid_ff || point_load;
   assign burst_ready = avg_load;

   always_comb begin
      avg_in.pen_up = burst.pen_up;
      for (int i = 0; i < 3; i++) begin
         avg_in.x_avg[i] = div3(burst.x_sum[i]);
         avg_in.y_avg[i] = div3(burst.y_sum[i]);
      end
      ax = filter_axis(avg_ff.x_avg, cfg.threshold);
      ay = filter_axis(avg_ff.y_avg, cfg.threshold);
      point_in = '0;
      if (avg_ff.pen_up) begin
         point_in.status = STATUS_PEN_UP;
      end else if (!(ax.ok && ay.ok)) begin
         point_in.status = STATUS_NOISY;
      end else begin
         point_in.status = STATUS_OK;
         point_in.raw_x  = ax.value;
         point_in.raw_y  = ay.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff   <= 1'b0;
         point_valid_ff <= 1'b0;
      end else begin
         if (avg_load)   avg_valid_ff   <= burst_valid;
         if (point_load) point_valid_ff <= avg_valid_ff;
      end
      if (avg_load && burst_valid)    avg_ff   <= avg_in;
      if (point_load && avg_valid_ff) point_ff <= point_in;
   end

   assign point_valid = point_valid_ff;
   assign point       = point_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (point_valid_ff && point_ff.status != STATUS_OK)
         |-> (point_ff.raw_x == '0) && (point_ff.raw_y == '0))
      else $error("rejected point carries raw data");

endmodule

>>> rtl/core/tsfm_map.sv
module tsfm_map (
   input  logic                  clock,
   input  logic                  reset,
   input  tsfm_pkg::cfg_type     cfg,
   input  logic                  point_valid,
   output logic                  point_ready,
   input  tsfm_pkg::point_type   point,
   tsfm_rsp_if.source            rsp
);
   import tsfm_pkg::*;

   logic                     prod_valid_ff;
   point_type                prod_point_ff;
   logic signed [PROD_W-1:0] p_xx_ff;
   logic signed [PROD_W-1:0] p_xy_ff;
   logic signed [PROD_W-1:0] p_yx_ff;
   logic signed [PROD_W-1:0] p_yy_ff;
   logic signed [ADC_BITS:0] op_x;
   logic signed [ADC_BITS:0] op_y;
   logic                     prod_load;
   logic                     out_load;
   logic                     out_valid_ff;
   point_type                out_point_ff;
   logic signed [DISP_W-1:0] disp_x_ff;
   logic signed [DISP_W-1:0] disp_y_ff;
   logic signed [DISP_W-1:0] disp_x_in;
   logic signed [DISP_W-1:0] disp_y_in;
   logic signed [ACC_W-1:0]  acc_x;
   logic signed [ACC_W-1:0]  acc_y;

   assign out_load    = !out_valid_ff || rsp.ready;
   assign prod_load   = !prod_valid_ff || out_load;
   assign point_ready = prod_load;
   assign op_x        = $signed({1'b0, point.raw_x});
   assign op_y        = $signed({1'b0, point.raw_y});

   always_comb begin
      acc_x = ACC_W'(p_xx_ff) + ACC_W'(p_xy_ff) + ACC_W'(cfg.off_x);
      acc_y = ACC_W'(p_yx_ff) + ACC_W'(p_yy_ff) + ACC_W'(cfg.off_y);
      disp_x_in = '0;
      disp_y_in = '0;
      if (prod_point_ff.status == STATUS_OK) begin
         disp_x_in = to_display(acc_x);
         disp_y_in = to_display(acc_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_load) prod_valid_ff <= point_valid;
         if (out_load)  out_valid_ff  <= prod_valid_ff;
      end
      if (prod_load && point_valid) begin
         prod_point_ff <= point;
         p_xx_ff       <= PROD_W'(cfg.gain_xx) * PROD_W'(op_x);
         p_xy_ff       <= PROD_W'(cfg.gain_xy) * PROD_W'(op_y);
         p_yx_ff       <= PROD_W'(cfg.gain_yx) * PROD_W'(op_x);
         p_yy_ff       <= PROD_W'(cfg.gain_yy) * PROD_W'(op_y);
      end
      if (out_load && prod_valid_ff) begin
         out_point_ff <= prod_point_ff;
         disp_x_ff    <= disp_x_in;
         disp_y_ff    <= disp_y_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.burst_status   = out_point_ff.status;
   assign rsp.filtered_raw_x = out_point_ff.raw_x;
   assign rsp.filtered_raw_y = out_point_ff.raw_y;
   assign rsp.display_x      = disp_x_ff;
   assign rsp.display_y      = disp_y_ff;

   a_reject_display: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_point_ff.status != STATUS_OK)
         |-> (disp_x_ff == '0) && (disp_y_ff == '0))
      else $error("rejected word carries display data");

endmodule

>>> rtl/core/touch_sample_filter_and_map_top.sv
// A word that ends a burst reaches rsp through the burst, average, point, product and output registers.
// Throughput: one sample word a cycle while rsp.ready does not hold the chain back; five register stages.
// Only the ninth sample of a burst or a pen lift gives a result word.
// Reset (synchronous, active high) clears group sums, count and stage valids,
// and loads the calibration registers with their defaults.
module touch_sample_filter_and_map_top (
   input  logic                            clock,
   input  logic                            reset,
   tsfm_req_if.sink                        req_chan,
   tsfm_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [tsfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsfm_pkg::CFG_W-1:0]      csr_wdata
);
   import tsfm_pkg::*;

   cfg_type   cfg;
   logic      burst_valid;
   logic      burst_ready;
   burst_type burst;
   logic      point_valid;
   logic      point_ready;
   point_type point;

   tsfm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tsfm_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   tsfm_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .point_valid (point_valid),
      .point_ready (point_ready),
      .point       (point)
   );

   tsfm_map u_map (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .point_valid (point_valid),
      .point_ready (point_ready),
      .point       (point),
      .rsp         (rsp_chan)
   );

endmodule
